// ----- rtl/refcounted_page_allocator_assert.svh -----
// Assertion helpers, clocked on clk_i, quiet while rst_ni is low
`ifndef REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define RCPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcpa assertion failed");

// next-cycle implication
`define RCPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcpa assertion failed");

`endif

// ----- rtl/rcpa_pkg.sv -----
package rcpa_pkg;

  localparam int unsigned PAGE_W    = 16;
  localparam int unsigned REG_W     = 17;
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned CNT_OUT_W = 8;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned FREE_W    = 17;

  localparam logic [REG_W-1:0] RESET_FIRST_PAGE = 17'h00000;
  localparam logic [REG_W-1:0] RESET_PAGE_LIMIT = 17'h10000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SEED  = 3'd0,
    FUNC_ALLOC = 3'd1,
    FUNC_FREE  = 3'd2,
    FUNC_INC   = 3'd3,
    FUNC_DEC   = 3'd4,
    FUNC_READ  = 3'd5
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_FIRST_PAGE = 1'b0,
    CFG_PAGE_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  typedef enum logic {
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // status flags from datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic clear_last;
  } seq_in_t;

  // sequencer strobes to datapath
  typedef struct packed {
    logic idle;
    logic accept;
    logic commit;
    logic clearing;
  } ctrl_t;

endpackage

// ----- rtl/refcounted_page_allocator.sv -----
// Page allocator: LIFO free stack plus per-page reference count table.
// Result registered on out_valid_o at commit; one transaction at a time, with
// in_stall_o high from accept to commit, set by the read-then-write of the
// single-port-per-side count and stack memories; commit waits while output stalls.
// Reset: after rst_ni rises the count table is swept to zero, one page a cycle,
// with in_stall_o high; config writes are taken throughout.
`include "refcounted_page_allocator_assert.svh"

module refcounted_page_allocator #(
  parameter int unsigned NUM_PAGES  = 65536,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 cfg_we_i,
  input  logic                                 cfg_index_i,
  input  logic [rcpa_pkg::REG_W-1:0]           cfg_data_i,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [rcpa_pkg::FUNC_W-1:0]          func_i,
  input  logic [rcpa_pkg::PAGE_W-1:0]          page_number_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [rcpa_pkg::PAGE_W-1:0]          page_out_o,
  output logic                                 granted_o,
  output logic [rcpa_pkg::CNT_OUT_W-1:0]       ref_count_o,
  output logic [rcpa_pkg::FREE_W-1:0]          free_count_o,
  output logic [rcpa_pkg::STAT_W-1:0]          status_o
);

  import rcpa_pkg::*;

  localparam int unsigned AW = $clog2(NUM_PAGES);
  localparam int unsigned DW = $clog2(NUM_PAGES + 1);
  localparam int unsigned CW = COUNT_BITS;
  localparam int unsigned XW = (AW > PAGE_W) ? AW : PAGE_W;
  localparam int unsigned FW = (DW > FREE_W) ? DW : FREE_W;
  localparam int unsigned OW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  function automatic logic [AW-1:0] page_idx(input logic [PAGE_W-1:0] p);
    logic [XW-1:0] w;
    w = XW'(p);
    return w[AW-1:0];
  endfunction

  function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [CW-1:0] c);
    logic [OW-1:0] w;
    w = OW'(c);
    return w[CNT_OUT_W-1:0];
  endfunction

  function automatic logic [FREE_W-1:0] free_out(input logic [DW-1:0] d);
    logic [FW-1:0] w;
    w = FW'(d);
    return w[FREE_W-1:0];
  endfunction

  // ---------------- config ----------------
  logic [REG_W-1:0] first_q, limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= RESET_FIRST_PAGE;
      limit_q <= RESET_PAGE_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FIRST_PAGE: first_q <= cfg_data_i;
        CFG_PAGE_LIMIT: limit_q <= cfg_data_i;
        default:        first_q <= first_q;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  seq_in_t seq;
  ctrl_t   ctrl;

  logic          out_valid_q;
  logic [AW-1:0] clr_q, clr_d;

  assign seq.in_valid   = in_valid_i;
  assign seq.out_busy   = out_valid_q && out_stall_i;
  assign seq.clear_last = (clr_q == AW'(NUM_PAGES - 1));

  rcpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seq_i  (seq),
    .ctrl_o (ctrl)
  );

  assign in_stall_o = !ctrl.idle;

  assign clr_d = ctrl.clearing ? clr_q + AW'(1) : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  // ---------------- transaction registers ----------------
  logic [FUNC_W-1:0] func_q;
  logic [PAGE_W-1:0] page_q;
  logic [DW-1:0]     depth_q, depth_d;

  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      func_q <= func_i;
      page_q <= page_number_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  // ---------------- memories ----------------
  logic              ref_we, stk_we;
  logic [AW-1:0]     ref_waddr, ref_raddr, stk_waddr, stk_raddr;
  logic [CW-1:0]     ref_wdata, ref_rdata;
  logic [PAGE_W-1:0] stk_wdata, stk_rdata;
  logic [DW-1:0]     depth_m1;
  logic [AW-1:0]     ref_waddr_mux;
  logic [CW-1:0]     ref_wdata_mux;

  // read at accept from the input; hold the same address while waiting
  assign ref_raddr = ctrl.idle ? page_idx(page_number_i) : page_idx(page_q);
  assign depth_m1  = depth_q - DW'(1);
  assign stk_raddr = depth_m1[AW-1:0];

  rcpa_ram #(.WIDTH(CW), .DEPTH(NUM_PAGES)) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr_mux),
    .wdata_i (ref_wdata_mux),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rdata)
  );

  rcpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // ---------------- count unit ----------------
  cnt_op_e       cnt_op;
  logic [CW-1:0] cnt_new;

  assign cnt_op = ((func_q == FUNC_FREE) || (func_q == FUNC_DEC)) ? CNT_DEC : CNT_INC;

  rcpa_count_unit #(.W(CW)) u_count (
    .op_i  (cnt_op),
    .cnt_i (ref_rdata),
    .cnt_o (cnt_new)
  );

  // ---------------- execute ----------------
  logic              in_range, full, empty;
  logic [PAGE_W-1:0] res_page;
  logic              res_grant;
  logic [CW-1:0]     res_cnt;
  status_e           res_stat;
  logic              do_ref, do_push, do_pop;

  assign in_range = ({1'b0, page_q} >= first_q) && ({1'b0, page_q} < limit_q)
                    && (32'(page_q) < 32'(NUM_PAGES));
  assign full  = (depth_q >= DW'(NUM_PAGES));
  assign empty = (depth_q == '0);

  always_comb begin
    res_page  = page_q;
    res_grant = 1'b0;
    res_cnt   = ref_rdata;
    res_stat  = STAT_OK;
    do_ref    = 1'b0;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    ref_wdata = ref_rdata;
    ref_waddr = page_idx(page_q);
    if (func_q == FUNC_ALLOC) begin
      if (empty) begin
        res_page = '0;
        res_cnt  = '0;
        res_stat = STAT_EMPTY;
      end else begin
        do_pop    = 1'b1;
        do_ref    = 1'b1;
        ref_waddr = page_idx(stk_rdata);
        ref_wdata = CW'(1);
        res_page  = stk_rdata;
        res_grant = 1'b1;
        res_cnt   = CW'(1);
      end
    end else if (!in_range) begin
      res_cnt  = '0;
      res_stat = STAT_RANGE;
    end else begin
      unique case (func_q)
        FUNC_SEED: begin
          if (full) begin
            res_stat = STAT_FULL;
          end else begin
            do_ref    = 1'b1;
            do_push   = 1'b1;
            ref_wdata = '0;
            res_cnt   = '0;
          end
        end
        FUNC_FREE: begin
          if ((cnt_new == '0) && full) begin
            res_stat = STAT_FULL;
          end else begin
            do_ref    = 1'b1;
            do_push   = (cnt_new == '0);
            ref_wdata = cnt_new;
            res_cnt   = cnt_new;
          end
        end
        FUNC_INC, FUNC_DEC: begin
          do_ref    = 1'b1;
          ref_wdata = cnt_new;
          res_cnt   = cnt_new;
        end
        default: res_cnt = ref_rdata;
      endcase
    end
  end

  // clear sweep owns the count table write port until the block goes idle
  always_comb begin
    if (ctrl.clearing) begin
      ref_we        = 1'b1;
      ref_waddr_mux = clr_q;
      ref_wdata_mux = '0;
    end else begin
      ref_we        = ctrl.commit && do_ref;
      ref_waddr_mux = ref_waddr;
      ref_wdata_mux = ref_wdata;
    end
  end

  assign stk_we    = ctrl.commit && do_push;
  assign stk_waddr = depth_q[AW-1:0];
  assign stk_wdata = page_q;

  always_comb begin
    depth_d = depth_q;
    if (ctrl.commit && do_push) depth_d = depth_q + DW'(1);
    if (ctrl.commit && do_pop)  depth_d = depth_m1;
  end

  // ---------------- result register ----------------
  logic [PAGE_W-1:0]    page_out_q;
  logic                 granted_q;
  logic [CNT_OUT_W-1:0] ref_count_q;
  logic [FREE_W-1:0]    free_count_q;
  logic [STAT_W-1:0]    status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      page_out_q   <= res_page;
      granted_q    <= res_grant;
      ref_count_q  <= cnt_out(res_cnt);
      free_count_q <= free_out(depth_d);
      status_q     <= res_stat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign page_out_o   = page_out_q;
  assign granted_o    = granted_q;
  assign ref_count_o  = ref_count_q;
  assign free_count_o = free_count_q;
  assign status_o     = status_q;

  // ---------------- checks ----------------
  `RCPA_ASSERT_NOW(a_depth_bound, 1'b1, depth_q <= DW'(NUM_PAGES))
  `RCPA_ASSERT_NOW(a_grant_ok, out_valid_o && granted_o, (status_o == STAT_OK) && (ref_count_o == CNT_OUT_W'(1)))
  `RCPA_ASSERT_NEXT(a_depth_hold, !ctrl.commit, $stable(depth_q))
  `RCPA_ASSERT_NOW(a_no_overwrite, ctrl.commit, !(out_valid_q && out_stall_i))

endmodule

// ----- rtl/rcpa_ram.sv -----
module rcpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rcpa_count_unit.sv -----
module rcpa_count_unit #(
  parameter int unsigned W = 8
) (
  input  rcpa_pkg::cnt_op_e op_i,
  input  logic [W-1:0]      cnt_i,
  output logic [W-1:0]      cnt_o
);

  import rcpa_pkg::*;

  logic [W-1:0] step;
  logic [W-1:0] sum;
  logic         sat;

  // one adder: +1 or +all-ones (i.e. -1), held at the rails
  assign step = (op_i == CNT_INC) ? W'(1) : '1;
  assign sum  = cnt_i + step;
  assign sat  = (op_i == CNT_INC) ? (cnt_i == '1) : (cnt_i == '0);
  assign cnt_o = sat ? cnt_i : sum;

endmodule

// ----- rtl/rcpa_ctrl.sv -----
module rcpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rcpa_pkg::seq_in_t seq_i,
  output rcpa_pkg::ctrl_t   ctrl_o
);

  import rcpa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (seq_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (seq_i.in_valid) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!seq_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      S_CLEAR: ctrl_o.clearing = 1'b1;
      S_IDLE: begin
        ctrl_o.idle   = 1'b1;
        ctrl_o.accept = seq_i.in_valid;
      end
      S_EXEC:  ctrl_o.commit = !seq_i.out_busy;
      default: ctrl_o = '0;
    endcase
  end

endmodule
